// ----- hw/rtl/expert_replica_route_apply_defines.svh -----
// Assertion macros for the route-apply RTL.
`ifndef EXPERT_REPLICA_ROUTE_APPLY_DEFINES_SVH
`define EXPERT_REPLICA_ROUTE_APPLY_DEFINES_SVH
`ifndef ASSERT_OFF
// Check that is suspended while reset is asserted.
`define ERRA_CHECK(lbl, prop) lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
    prop) else $error("%m: check failed");
// Check that also runs during reset.
`define ERRA_CHECK_RST(lbl, prop) lbl: assert property (@(posedge aclk) prop) \
    else $error("%m: reset check failed");
`else
`define ERRA_CHECK(lbl, prop)
`define ERRA_CHECK_RST(lbl, prop)
`endif
`endif

// ----- hw/rtl/erra_pkg.sv -----
`timescale 1ns / 1ps
package erra_pkg;

    localparam int ROUTES       = 1024;
    localparam int ROUTE_AW     = 10;
    localparam int TOKEN_W      = 8;
    localparam int EP_MAX       = 16;
    localparam int TOTAL_GROUPS = 32;
    localparam int SLOT_W       = 5;
    localparam int GROUP_AW     = TOKEN_W + SLOT_W;
    localparam int GROUPS       = 8192;
    localparam int QDEPTH       = 2;
    localparam int QAW          = 1;

    // Request kinds.
    localparam logic [1:0] OP_LOAD_ROUTE = 2'd0;
    localparam logic [1:0] OP_LOAD_COUNT = 2'd1;
    localparam logic [1:0] OP_APPLY      = 2'd2;
    localparam logic [1:0] OP_READ_COUNT = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_CUR_BAD  = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_CAND_BAD = 2'd3;

    // Register indexes.
    localparam logic [2:0] REG_EP_SIZE   = 3'd0;
    localparam logic [2:0] REG_NUM_LVL   = 3'd1;
    localparam logic [2:0] REG_LVL_SIZE0 = 3'd2;
    localparam logic [2:0] REG_LVL_SIZE1 = 3'd3;
    localparam logic [2:0] REG_LVL_SIZE2 = 3'd4;
    localparam logic [2:0] REG_LVL_OFS0  = 3'd5;
    localparam logic [2:0] REG_LVL_OFS1  = 3'd6;
    localparam logic [2:0] REG_LVL_OFS2  = 3'd7;

    typedef struct packed {
        logic [4:0]      ep_size;
        logic [1:0]      num_levels;
        logic [2:0][4:0] level_size;
        logic [2:0][4:0] level_offset;
    } erra_cfg_t;

    typedef struct packed {
        logic [1:0]          op;
        logic [ROUTE_AW-1:0] route_index;
        logic [TOKEN_W-1:0]  token_id;
        logic [3:0]          rank;
        logic [31:0]         score;
        logic [31:0]         route_hash;
        logic [SLOT_W-1:0]   group_slot;
        logic [15:0]         count_value;
        logic [4:0]          ep;
        logic                rank_ok;
    } erra_cmd_t;

    typedef struct packed {
        logic [4:0]             rank;
        logic [31:0]            min_score;
        logic [4:0]             tie_count;
        logic [EP_MAX-1:0][4:0] ties;
    } erra_row_t;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [4:0]  divisor;
        logic [5:0]  steps;
    } erra_div_req_t;

    typedef struct packed {
        logic       busy;
        logic       done;
        logic [3:0] quot;
        logic [4:0] rem;
    } erra_div_rsp_t;

    typedef struct packed {
        logic busy;
        logic pop;
    } erra_bstat_t;

endpackage

// ----- hw/rtl/expert_replica_route_apply.sv -----
`timescale 1ns / 1ps
// An accepted request is popped by the sequencer, which ends in S_FIN and raises the result valid;
// an apply first reads the route row, a tie pick runs the serial divider, and a changed rank
// walks the levels, moving a group count from the old group to the new one where they differ.
// The back end executes one request at a time; it pops the next only when idle and no result waits.
// Reset (aresetn low, synchronous) clears control state and restores the registers;
// route and group count memories are not cleared and are undefined until written.
`include "expert_replica_route_apply_defines.svh"
module expert_replica_route_apply (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    input  logic         s_tvalid,
    output logic         s_tready,
    // route_index, token_id, rank, score, route_hash, group_slot, count_value
    input  logic [111:0] s_tdata,
    input  logic [1:0]   s_tuser,   // req_type
    output logic         m_tvalid,
    input  logic         m_tready,
    // route_rank, changed, min_score, tie_count, read_value
    output logic [63:0]  m_tdata,
    output logic [1:0]   m_tuser    // status
);
    import erra_pkg::*;

    erra_cfg_t   cfg_reg;
    erra_cmd_t   front_cmd;
    erra_cmd_t   q_data;
    erra_bstat_t bstat;
    logic        q_push, q_pop, q_full, q_empty;
    logic [1:0]  q_count;
    logic        cfg_wr;

    // Register file.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ep_size      <= 5'd16;
            cfg_reg.num_levels   <= 2'd1;
            cfg_reg.level_size   <= {5'd1, 5'd1, 5'd1};
            cfg_reg.level_offset <= '0;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                REG_EP_SIZE:   cfg_reg.ep_size         <= pwdata[4:0];
                REG_NUM_LVL:   cfg_reg.num_levels      <= pwdata[1:0];
                REG_LVL_SIZE0: cfg_reg.level_size[0]   <= pwdata[4:0];
                REG_LVL_SIZE1: cfg_reg.level_size[1]   <= pwdata[4:0];
                REG_LVL_SIZE2: cfg_reg.level_size[2]   <= pwdata[4:0];
                REG_LVL_OFS0:  cfg_reg.level_offset[0] <= pwdata[4:0];
                REG_LVL_OFS1:  cfg_reg.level_offset[1] <= pwdata[4:0];
                REG_LVL_OFS2:  cfg_reg.level_offset[2] <= pwdata[4:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_EP_SIZE:   prdata = {27'd0, cfg_reg.ep_size};
            REG_NUM_LVL:   prdata = {30'd0, cfg_reg.num_levels};
            REG_LVL_SIZE0: prdata = {27'd0, cfg_reg.level_size[0]};
            REG_LVL_SIZE1: prdata = {27'd0, cfg_reg.level_size[1]};
            REG_LVL_SIZE2: prdata = {27'd0, cfg_reg.level_size[2]};
            REG_LVL_OFS0:  prdata = {27'd0, cfg_reg.level_offset[0]};
            REG_LVL_OFS1:  prdata = {27'd0, cfg_reg.level_offset[1]};
            REG_LVL_OFS2:  prdata = {27'd0, cfg_reg.level_offset[2]};
            default:       prdata = 32'd0;
        endcase
    end

    // Front end: decode requests into the queue.
    erra_front u_front (
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .cfg     (cfg_reg),
        .cmd     (front_cmd)
    );

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && s_tready;

    erra_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (front_cmd),
        .pop       (q_pop),
        .pop_data  (q_data),
        .full      (q_full),
        .empty     (q_empty),
        .count     (q_count)
    );

    // Back end: executes one request at a time.
    erra_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_empty  (q_empty),
        .q_data   (q_data),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .bstat    (bstat)
    );

    // Cross-module checks.
    `ERRA_CHECK(a_pop_nonempty, q_pop |-> !q_empty)
    `ERRA_CHECK(a_push_count, (q_push && !q_pop) |=> (q_count == $past(q_count) + 2'd1))
    `ERRA_CHECK(a_pop_busy, bstat.pop |=> bstat.busy)
    `ERRA_CHECK(a_result_from_work, $rose(m_tvalid) |-> $past(bstat.busy))
    `ERRA_CHECK_RST(a_reset_quiet, !aresetn |=> !m_tvalid)

endmodule

// ----- hw/rtl/erra_div.sv -----
`timescale 1ns / 1ps
module erra_div (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  erra_pkg::erra_div_req_t req,
    output erra_pkg::erra_div_rsp_t rsp
);
    import erra_pkg::*;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [31:0] dvd_reg, dvd_next;
    logic [4:0]  dsr_reg, dsr_next;
    logic [4:0]  rem_reg, rem_next;
    logic [3:0]  quot_reg, quot_next;
    logic [5:0]  trial;
    logic        ge;

    // One restoring step per cycle, most significant dividend bit first.
    always_comb begin
        trial     = {rem_reg, dvd_reg[31]};
        ge        = trial >= {1'b0, dsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = req.steps;
            dvd_next  = req.dividend;
            dsr_next  = req.divisor;
            rem_next  = 5'd0;
            quot_next = 4'd0;
        end else if (busy_reg) begin
            rem_next  = ge ? 5'(trial - {1'b0, dsr_reg}) : trial[4:0];
            quot_next = {quot_reg[2:0], ge};
            dvd_next  = {dvd_reg[30:0], 1'b0};
            cnt_next  = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg  <= cnt_next;
        dvd_reg  <= dvd_next;
        dsr_reg  <= dsr_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
    assign rsp.rem  = rem_reg;

endmodule

// ----- hw/rtl/erra_front.sv -----
`timescale 1ns / 1ps
module erra_front (
    input  logic [111:0]        s_tdata,
    input  logic [1:0]          s_tuser,
    input  erra_pkg::erra_cfg_t cfg,
    output erra_pkg::erra_cmd_t cmd
);
    import erra_pkg::*;

    logic [4:0] ep;

    // Clamp the rank count to 1..EP_MAX.
    always_comb begin
        if (cfg.ep_size == 5'd0) begin
            ep = 5'd1;
        end else if (cfg.ep_size > 5'(EP_MAX)) begin
            ep = 5'(EP_MAX);
        end else begin
            ep = cfg.ep_size;
        end
    end

    // Unpack the request and tag it with what the back end needs early.
    always_comb begin
        cmd.op          = s_tuser;
        cmd.route_index = s_tdata[9:0];
        cmd.token_id    = s_tdata[17:10];
        cmd.rank        = s_tdata[21:18];
        cmd.score       = s_tdata[53:22];
        cmd.route_hash  = s_tdata[85:54];
        cmd.group_slot  = s_tdata[90:86];
        cmd.count_value = s_tdata[106:91];
        cmd.ep          = ep;
        cmd.rank_ok     = {1'b0, s_tdata[21:18]} < ep;
    end

endmodule

// ----- hw/rtl/erra_queue.sv -----
`timescale 1ns / 1ps
module erra_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  erra_pkg::erra_cmd_t push_data,
    input  logic                pop,
    output erra_pkg::erra_cmd_t pop_data,
    output logic                full,
    output logic                empty,
    output logic [1:0]          count
);
    import erra_pkg::*;

    erra_cmd_t          mem_reg [QDEPTH];
    logic [QAW-1:0]     wp_reg, rp_reg;
    logic [1:0]         cnt_reg;

    // Pointer and fill bookkeeping.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (pop) begin
                rp_reg <= rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= push_data;
        end
    end

    assign pop_data = mem_reg[rp_reg];
    assign full     = cnt_reg == 2'(QDEPTH);
    assign empty    = cnt_reg == 2'd0;
    assign count    = cnt_reg;

endmodule

// ----- hw/rtl/erra_back.sv -----
`timescale 1ns / 1ps
module erra_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  erra_pkg::erra_cfg_t   cfg,
    input  logic                  q_empty,
    input  erra_pkg::erra_cmd_t   q_data,
    output logic                  q_pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [63:0]           m_tdata,  // route_rank, changed, min_score, tie_count, read_value
    output logic [1:0]            m_tuser,  // status
    output erra_pkg::erra_bstat_t bstat
);
    import erra_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CMD    = 4'd1;
    localparam logic [3:0] S_GRD    = 4'd2;
    localparam logic [3:0] S_RROW   = 4'd3;
    localparam logic [3:0] S_EVAL   = 4'd4;
    localparam logic [3:0] S_DIV    = 4'd5;
    localparam logic [3:0] S_PICK   = 4'd6;
    localparam logic [3:0] S_LVL    = 4'd7;
    localparam logic [3:0] S_OG     = 4'd8;
    localparam logic [3:0] S_NG     = 4'd9;
    localparam logic [3:0] S_DEC_RD = 4'd10;
    localparam logic [3:0] S_DEC_WR = 4'd11;
    localparam logic [3:0] S_INC_RD = 4'd12;
    localparam logic [3:0] S_INC_WR = 4'd13;
    localparam logic [3:0] S_FIN    = 4'd14;

    // Route rows and group counts.
    erra_row_t   rmem [ROUTES];
    logic [15:0] gmem [GROUPS];
    erra_row_t   route_q;
    logic [15:0] gmem_q;

    logic                rmem_we, rmem_re;
    erra_row_t           rmem_wdata;
    logic                gmem_we, gmem_re;
    logic [GROUP_AW-1:0] gmem_addr;
    logic [15:0]         gmem_wdata;

    logic [3:0]  state_reg, state_next;
    erra_cmd_t   cmd_reg, cmd_next;
    erra_row_t   row_reg, row_next;
    logic [4:0]  ins_reg, ins_next;
    logic [4:0]  ties_reg, ties_next;
    logic [3:0]  new_reg, new_next;
    logic [1:0]  lvl_reg, lvl_next;
    logic [3:0]  og_reg, og_next;
    logic [5:0]  os_reg, os_next;
    logic [5:0]  ns_reg, ns_next;

    logic        out_valid_reg, out_valid_next;
    logic [1:0]  out_status_reg, out_status_next;
    logic [3:0]  out_rank_reg, out_rank_next;
    logic        out_changed_reg, out_changed_next;
    logic [31:0] out_ms_reg, out_ms_next;
    logic [4:0]  out_tc_reg, out_tc_next;
    logic [15:0] out_read_reg, out_read_next;

    erra_div_req_t div_req;
    erra_div_rsp_t div_rsp;

    logic [4:0]             ties_cl;
    logic [EP_MAX-1:0]      below;
    logic [4:0]             ins_cnt;
    logic [EP_MAX-1:0][4:0] reset_list;
    logic [EP_MAX-1:0][4:0] shift_list;
    logic [4:0]             tgt;
    logic [4:0]             idx;
    logic [4:0]             cand;
    logic [4:0]             lvl_size;
    logic [4:0]             lvl_ofs;
    logic                   lvl_skip;

    erra_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Tie list arithmetic on the fetched row.
    always_comb begin
        ties_cl = row_reg.tie_count;
        if (ties_cl == 5'd0) begin
            ties_cl = 5'd1;
        end else if (ties_cl > cmd_reg.ep) begin
            ties_cl = cmd_reg.ep;
        end
        for (int i = 0; i < EP_MAX; i++) begin
            below[i]      = (5'(i) < ties_cl) && (row_reg.ties[i] < {1'b0, cmd_reg.rank});
            reset_list[i] = (i == 0) ? {1'b0, cmd_reg.rank} : cmd_reg.ep;
            if (5'(i) == ins_reg) begin
                shift_list[i] = {1'b0, cmd_reg.rank};
            end else if (5'(i) > ins_reg && 5'(i) < cmd_reg.ep) begin
                shift_list[i] = row_reg.ties[(i + EP_MAX - 1) % EP_MAX];
            end else begin
                shift_list[i] = row_reg.ties[i];
            end
        end
        ins_cnt = 5'($countones(below));
        tgt     = div_rsp.rem;
        idx     = tgt - 5'(tgt > ins_reg);
        cand    = (tgt == ins_reg) ? {1'b0, cmd_reg.rank} : row_reg.ties[idx[3:0]];
    end

    // Per-level group size and offset; a zero size acts as one.
    always_comb begin
        case (lvl_reg)
            2'd0: begin
                lvl_size = cfg.level_size[0];
                lvl_ofs  = cfg.level_offset[0];
                lvl_skip = 1'b0;
            end
            2'd1: begin
                lvl_size = cfg.level_size[1];
                lvl_ofs  = cfg.level_offset[1];
                lvl_skip = cfg.num_levels < 2'd2;
            end
            2'd2: begin
                lvl_size = cfg.level_size[2];
                lvl_ofs  = cfg.level_offset[2];
                lvl_skip = cfg.num_levels < 2'd3;
            end
            default: begin
                lvl_size = 5'd1;
                lvl_ofs  = 5'd0;
                lvl_skip = 1'b1;
            end
        endcase
        if (lvl_size == 5'd0) begin
            lvl_size = 5'd1;
        end
    end

    // Sequencer.
    always_comb begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        row_next         = row_reg;
        ins_next         = ins_reg;
        ties_next        = ties_reg;
        new_next         = new_reg;
        lvl_next         = lvl_reg;
        og_next          = og_reg;
        os_next          = os_reg;
        ns_next          = ns_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_status_next  = out_status_reg;
        out_rank_next    = out_rank_reg;
        out_changed_next = out_changed_reg;
        out_ms_next      = out_ms_reg;
        out_tc_next      = out_tc_reg;
        out_read_next    = out_read_reg;
        q_pop            = 1'b0;
        rmem_we          = 1'b0;
        rmem_re          = 1'b0;
        rmem_wdata       = row_reg;
        gmem_we          = 1'b0;
        gmem_re          = 1'b0;
        gmem_addr        = {cmd_reg.token_id, cmd_reg.group_slot};
        gmem_wdata       = cmd_reg.count_value;
        div_req.start    = 1'b0;
        div_req.dividend = {cmd_reg.route_hash};
        div_req.divisor  = lvl_size;
        div_req.steps    = 6'd4;

        case (state_reg)
            S_IDLE: begin
                if (!q_empty && !out_valid_reg) begin
                    q_pop            = 1'b1;
                    cmd_next         = q_data;
                    out_status_next  = ST_DONE;
                    out_rank_next    = 4'd0;
                    out_changed_next = 1'b0;
                    out_ms_next      = 32'd0;
                    out_tc_next      = 5'd0;
                    out_read_next    = 16'd0;
                    lvl_next         = 2'd0;
                    state_next       = S_CMD;
                end
            end
            S_CMD: begin
                case (cmd_reg.op)
                    OP_LOAD_ROUTE: begin
                        rmem_we              = 1'b1;
                        rmem_wdata.rank      = {1'b0, cmd_reg.rank};
                        rmem_wdata.min_score = cmd_reg.score;
                        rmem_wdata.tie_count = 5'd1;
                        rmem_wdata.ties      = reset_list;
                        out_rank_next        = cmd_reg.rank;
                        out_ms_next          = cmd_reg.score;
                        out_tc_next          = 5'd1;
                        state_next           = S_FIN;
                    end
                    OP_LOAD_COUNT: begin
                        gmem_we    = 1'b1;
                        state_next = S_FIN;
                    end
                    OP_READ_COUNT: begin
                        gmem_re    = 1'b1;
                        state_next = S_GRD;
                    end
                    default: begin
                        rmem_re    = 1'b1;
                        state_next = S_RROW;
                    end
                endcase
            end
            S_GRD: begin
                out_read_next = gmem_q;
                state_next    = S_FIN;
            end
            S_RROW: begin
                row_next   = route_q;
                state_next = S_EVAL;
            end
            S_EVAL: begin
                out_rank_next = row_reg.rank[3:0];
                out_ms_next   = row_reg.min_score;
                out_tc_next   = row_reg.tie_count;
                state_next    = S_FIN;
                if (!cmd_reg.rank_ok) begin
                    out_status_next = ST_CAND_BAD;
                end else if (row_reg.rank >= cmd_reg.ep) begin
                    out_status_next = ST_CUR_BAD;
                end else if ($signed(cmd_reg.score) < $signed(row_reg.min_score)) begin
                    // Strictly better score: the offered rank takes the route alone.
                    rmem_we              = 1'b1;
                    rmem_wdata.rank      = {1'b0, cmd_reg.rank};
                    rmem_wdata.min_score = cmd_reg.score;
                    rmem_wdata.tie_count = 5'd1;
                    rmem_wdata.ties      = reset_list;
                    out_rank_next        = cmd_reg.rank;
                    out_ms_next          = cmd_reg.score;
                    out_tc_next          = 5'd1;
                    new_next             = cmd_reg.rank;
                    if ({1'b0, cmd_reg.rank} != row_reg.rank) begin
                        out_changed_next = 1'b1;
                        state_next       = S_LVL;
                    end
                end else if (cmd_reg.score == row_reg.min_score) begin
                    if (ins_cnt >= cmd_reg.ep) begin
                        out_status_next = ST_FULL;
                    end else begin
                        // Equal score: pick among the ties by hash modulo.
                        ins_next         = ins_cnt;
                        ties_next        = ties_cl;
                        div_req.start    = 1'b1;
                        div_req.dividend = cmd_reg.route_hash;
                        div_req.divisor  = ties_cl + 5'd1;
                        div_req.steps    = 6'd32;
                        state_next       = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    state_next = S_PICK;
                end
            end
            S_PICK: begin
                state_next = S_FIN;
                if (cand >= cmd_reg.ep) begin
                    out_status_next = ST_CAND_BAD;
                end else begin
                    rmem_we              = 1'b1;
                    rmem_wdata.rank      = cand;
                    rmem_wdata.tie_count = ties_reg + 5'd1;
                    rmem_wdata.ties      = shift_list;
                    out_rank_next        = cand[3:0];
                    out_tc_next          = ties_reg + 5'd1;
                    new_next             = cand[3:0];
                    if (cand != row_reg.rank) begin
                        out_changed_next = 1'b1;
                        state_next       = S_LVL;
                    end
                end
            end
            S_LVL: begin
                if (lvl_skip) begin
                    state_next = S_FIN;
                end else begin
                    div_req.start    = 1'b1;
                    div_req.dividend = {row_reg.rank[3:0], 28'd0};
                    state_next       = S_OG;
                end
            end
            S_OG: begin
                if (div_rsp.done) begin
                    og_next          = div_rsp.quot;
                    div_req.start    = 1'b1;
                    div_req.dividend = {new_reg, 28'd0};
                    state_next       = S_NG;
                end
            end
            S_NG: begin
                if (div_rsp.done) begin
                    os_next = {1'b0, lvl_ofs} + {2'b0, og_reg};
                    ns_next = {1'b0, lvl_ofs} + {2'b0, div_rsp.quot};
                    if (og_reg == div_rsp.quot) begin
                        lvl_next   = lvl_reg + 2'd1;
                        state_next = S_LVL;
                    end else begin
                        state_next = S_DEC_RD;
                    end
                end
            end
            S_DEC_RD: begin
                gmem_addr = {cmd_reg.token_id, os_reg[4:0]};
                if (os_reg < 6'(TOTAL_GROUPS)) begin
                    gmem_re    = 1'b1;
                    state_next = S_DEC_WR;
                end else begin
                    state_next = S_INC_RD;
                end
            end
            S_DEC_WR: begin
                gmem_addr  = {cmd_reg.token_id, os_reg[4:0]};
                gmem_we    = 1'b1;
                gmem_wdata = gmem_q - 16'd1;
                state_next = S_INC_RD;
            end
            S_INC_RD: begin
                gmem_addr = {cmd_reg.token_id, ns_reg[4:0]};
                if (ns_reg < 6'(TOTAL_GROUPS)) begin
                    gmem_re    = 1'b1;
                    state_next = S_INC_WR;
                end else begin
                    lvl_next   = lvl_reg + 2'd1;
                    state_next = S_LVL;
                end
            end
            S_INC_WR: begin
                gmem_addr  = {cmd_reg.token_id, ns_reg[4:0]};
                gmem_we    = 1'b1;
                gmem_wdata = gmem_q + 16'd1;
                lvl_next   = lvl_reg + 2'd1;
                state_next = S_LVL;
            end
            S_FIN: begin
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Route row memory.
    always_ff @(posedge aclk) begin
        if (rmem_we) begin
            rmem[cmd_reg.route_index] <= rmem_wdata;
        end
        if (rmem_re) begin
            route_q <= rmem[cmd_reg.route_index];
        end
    end

    // Group count memory.
    always_ff @(posedge aclk) begin
        if (gmem_we) begin
            gmem[gmem_addr] <= gmem_wdata;
        end
        if (gmem_re) begin
            gmem_q <= gmem[gmem_addr];
        end
    end

    // State and payload registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
        cmd_reg         <= cmd_next;
        row_reg         <= row_next;
        ins_reg         <= ins_next;
        ties_reg        <= ties_next;
        new_reg         <= new_next;
        lvl_reg         <= lvl_next;
        og_reg          <= og_next;
        os_reg          <= os_next;
        ns_reg          <= ns_next;
        out_status_reg  <= out_status_next;
        out_rank_reg    <= out_rank_next;
        out_changed_reg <= out_changed_next;
        out_ms_reg      <= out_ms_next;
        out_tc_reg      <= out_tc_next;
        out_read_reg    <= out_read_next;
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tuser    = out_status_reg;
    assign m_tdata    = {6'd0, out_read_reg, out_tc_reg, out_ms_reg, out_changed_reg,
                         out_rank_reg};
    assign bstat.busy = state_reg != S_IDLE;
    assign bstat.pop  = q_pop;

endmodule
